@@ rtl/uld_pkg.sv @@
// ----------------------------------------------------------------------------
// uld_pkg
// Shared types and constants for the uudecode line decoder.
// ----------------------------------------------------------------------------
package uld_pkg;

   // Longest line, in decoded bytes, that a length character may announce
   localparam int unsigned MAX_LINE_BYTES = 45;

   // Character codes
   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] CH_BACKQUOTE = 8'd96;
   localparam logic [7:0] DIGIT_TOP    = 8'd95;
   localparam logic [7:0] LEN_TOP      = CH_SPACE + 8'(MAX_LINE_BYTES);

   // Status codes on the result channel
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_DIGIT  = 2'd1;
   localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

   // Queue between front and back; depth is a power of two
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request: one character of a line
   typedef struct packed {
      logic [7:0] ch;
      logic       line_start;
   } req_type;

   // Response: one decoded byte or an end-of-line marker
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       line_done;
      logic [1:0] status;
   } rsp_type;

   // Classified character handed from front to back
   typedef struct packed {
      logic       is_start;  // length character
      logic       char_ok;   // legal length or legal digit
      logic [5:0] value;     // byte count or 6-bit digit
   } cls_type;

endpackage

@@ rtl/uld_front.sv @@
// ----------------------------------------------------------------------------
// uld_front
// Accepts requests and classifies each character as a length or digit code.
// ----------------------------------------------------------------------------
module uld_front
   import uld_pkg::*;
(
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  logic    queue_full,
   output logic    push,
   output cls_type cls
);

   logic [7:0] ch_offset;
   logic       is_backquote;
   logic       len_in_range;
   logic       digit_in_range;

   // Take a request whenever the queue has room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Backquote maps to 0 through the low six bits of ch - space
   assign ch_offset      = req_payload.ch - CH_SPACE;
   assign is_backquote   = (req_payload.ch == CH_BACKQUOTE);
   assign len_in_range   = (req_payload.ch >= CH_SPACE) && (req_payload.ch <= LEN_TOP);
   assign digit_in_range = (req_payload.ch >= CH_SPACE) && (req_payload.ch <= DIGIT_TOP);

   always_comb begin
      cls.is_start = req_payload.line_start;
      cls.value    = ch_offset[5:0];
      if (req_payload.line_start) begin
         cls.char_ok = is_backquote || len_in_range;
      end else begin
         cls.char_ok = is_backquote || digit_in_range;
      end
   end

endmodule

@@ rtl/uld_queue.sv @@
// ----------------------------------------------------------------------------
// uld_queue
// Small FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module uld_queue
   import uld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type push_data,
   output logic    full,
   output logic    pop_valid,
   input  logic    pop,
   output cls_type pop_data
);

   cls_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/uld_back.sv @@
// ----------------------------------------------------------------------------
// uld_back
// Line state, digit grouping and byte assembly, with a registered response.
// ----------------------------------------------------------------------------
module uld_back
   import uld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cls_type q_data,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic       line_active_ff, line_active_in;
   logic [5:0] chars_left_ff,  chars_left_in;
   logic [1:0] quad_pos_ff,    quad_pos_in;
   logic [5:0] held_digit_ff,  held_digit_in;
   logic       rsp_valid_ff,   rsp_valid_in;
   rsp_type    rsp_ff,         rsp_in;

   logic       has_rsp;
   rsp_type    new_rsp;
   logic [7:0] asm_byte;
   logic [5:0] left_dec;

   // Take an entry when the output slot is free or drains this cycle
   assign q_pop    = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign left_dec = chars_left_ff - 6'd1;

   // Byte assembled from the held digit and the current one
   always_comb begin
      unique case (quad_pos_ff)
         2'd1:    asm_byte = {held_digit_ff[5:0], q_data.value[5:4]};
         2'd2:    asm_byte = {held_digit_ff[3:0], q_data.value[5:2]};
         2'd3:    asm_byte = {held_digit_ff[1:0], q_data.value};
         default: asm_byte = 8'd0;
      endcase
   end

   // Next line state and response for the entry at the queue head
   always_comb begin
      line_active_in = line_active_ff;
      chars_left_in  = chars_left_ff;
      quad_pos_in    = quad_pos_ff;
      held_digit_in  = held_digit_ff;
      has_rsp        = 1'b0;
      new_rsp        = '{data_byte: 8'd0, byte_valid: 1'b0, line_done: 1'b1,
                         status: STATUS_OK};
      priority if (q_data.is_start) begin
         line_active_in = 1'b0;
         chars_left_in  = 6'd0;
         quad_pos_in    = 2'd0;
         held_digit_in  = 6'd0;
         if (!q_data.char_ok) begin
            has_rsp        = 1'b1;
            new_rsp.status = STATUS_BAD_LENGTH;
         end else if (q_data.value == 6'd0) begin
            has_rsp = 1'b1;
         end else begin
            chars_left_in  = q_data.value;
            line_active_in = 1'b1;
         end
      end else if (!line_active_ff) begin
         // idle character, ignored
      end else if (!q_data.char_ok) begin
         line_active_in = 1'b0;
         chars_left_in  = 6'd0;
         quad_pos_in    = 2'd0;
         held_digit_in  = 6'd0;
         has_rsp        = 1'b1;
         new_rsp.status = STATUS_BAD_DIGIT;
      end else if (quad_pos_ff == 2'd0) begin
         held_digit_in = q_data.value;
         quad_pos_in   = 2'd1;
      end else begin
         has_rsp            = 1'b1;
         new_rsp.data_byte  = asm_byte;
         new_rsp.byte_valid = 1'b1;
         held_digit_in      = q_data.value;
         quad_pos_in        = quad_pos_ff + 2'd1;
         chars_left_in      = left_dec;
         if (left_dec == 6'd0) begin
            line_active_in    = 1'b0;
            quad_pos_in       = 2'd0;
            held_digit_in     = 6'd0;
         end else begin
            new_rsp.line_done = 1'b0;
         end
      end
   end

   // Output register
   always_comb begin
      rsp_in = rsp_ff;
      if (q_pop) begin
         rsp_valid_in = has_rsp;
         if (has_rsp) begin
            rsp_in = new_rsp;
         end
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         chars_left_ff  <= 6'd0;
         quad_pos_ff    <= 2'd0;
         held_digit_ff  <= 6'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (q_pop) begin
            line_active_ff <= line_active_in;
            chars_left_ff  <= chars_left_in;
            quad_pos_ff    <= quad_pos_in;
            held_digit_ff  <= held_digit_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // An idle decoder sits at the start of a digit group with nothing left
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !line_active_ff |-> (quad_pos_ff == 2'd0) && (chars_left_ff == 6'd0))
      else $error("idle decoder holds stale group state");

   // An active line always has bytes still to decode
   a_active_count: assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> (chars_left_ff != 6'd0))
      else $error("active line with zero bytes left");

   // Error responses end the line and carry no byte
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != STATUS_OK) |->
         rsp_ff.line_done && !rsp_ff.byte_valid)
      else $error("error response malformed");

   // A response that ends the line, final byte or error, leaves the decoder idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop && has_rsp && new_rsp.line_done |=> !line_active_ff)
      else $error("line still active after its final response");
`endif

endmodule

@@ rtl/uudecode_line_decoder.sv @@
// ----------------------------------------------------------------------------
// uudecode_line_decoder
// Streaming uuencoded line decoder, one character per request.
// ----------------------------------------------------------------------------
// Send one character per request, flagging the length character of each line
// with line_start. The block takes one character every clock cycle while the
// queue is not full; a decoded byte or end-of-line response is registered once
// its character leaves the queue, and is offered on the response port from
// then on. A four-entry queue sits between the classifier and the line
// decoder, so a stalled response port stops intake only once that queue and
// the response register are full. Characters that are ignored or that open a
// digit group produce no response. Errors (status 1 bad digit, 2 bad length)
// end the line; later characters are dropped until the next line_start.
module uudecode_line_decoder
   import uld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    push;
   logic    queue_full;
   cls_type cls;
   logic    q_valid;
   logic    q_pop;
   cls_type q_data;

   uld_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .cls         (cls)
   );

   uld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cls),
      .full      (queue_full),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   uld_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ dv/uudecode_line_decoder_checker.sv @@
// ----------------------------------------------------------------------------
// uudecode_line_decoder_checker
// Watches both channels of the line decoder, predicts every response from the
// accepted characters and compares it field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module uudecode_line_decoder_checker
   import uld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending,
   output int      n_bytes,
   output int      n_line_ends,
   output int      n_errors
);

   // Decoder state as seen by the predictor
   logic       in_line    = 1'b0;
   logic [5:0] bytes_left = '0;
   logic [1:0] digit_pos  = '0;
   logic [5:0] prev_digit = '0;

   rsp_type expected_rsp[$];

   initial begin
      fail_count  = 0;
      pending     = 0;
      n_bytes     = 0;
      n_line_ends = 0;
      n_errors    = 0;
   end

   // Advance the decoder by one accepted character, queue any response
   task automatic decode_char(input req_type r);
      rsp_type    e;
      logic [5:0] d;
      logic       emit;
      e    = '0;
      d    = '0;
      emit = 1'b0;
      if (r.line_start) begin
         // length character: always drops whatever line was in progress
         in_line    = 1'b0;
         bytes_left = '0;
         digit_pos  = '0;
         prev_digit = '0;
         if (r.ch == CH_BACKQUOTE || r.ch == CH_SPACE) begin
            e.line_done = 1'b1;
            e.status    = STATUS_OK;
            emit        = 1'b1;
         end else if (r.ch > CH_SPACE && r.ch <= LEN_TOP) begin
            bytes_left = 6'(r.ch - CH_SPACE);
            in_line    = 1'b1;
         end else begin
            e.line_done = 1'b1;
            e.status    = STATUS_BAD_LENGTH;
            emit        = 1'b1;
         end
      end else if (in_line) begin
         if (r.ch == CH_BACKQUOTE || (r.ch >= CH_SPACE && r.ch <= DIGIT_TOP)) begin
            d = (r.ch == CH_BACKQUOTE) ? 6'd0 : 6'(r.ch - CH_SPACE);
            if (digit_pos != 2'd0) begin
               case (digit_pos)
                  2'd1: begin
                     e.data_byte = {prev_digit, d[5:4]};
                  end
                  2'd2: begin
                     e.data_byte = {prev_digit[3:0], d[5:2]};
                  end
                  default: begin
                     e.data_byte = {prev_digit[1:0], d};
                  end
               endcase
               e.byte_valid = 1'b1;
               emit         = 1'b1;
               bytes_left   = bytes_left - 6'd1;
            end
            prev_digit = d;
            digit_pos  = digit_pos + 2'd1;
            if (emit && bytes_left == 6'd0) begin
               e.line_done = 1'b1;
               in_line     = 1'b0;
               digit_pos   = '0;
               prev_digit  = '0;
            end
         end else begin
            // bad digit ends the line, bytes already sent stand
            in_line     = 1'b0;
            bytes_left  = '0;
            digit_pos   = '0;
            prev_digit  = '0;
            e.line_done = 1'b1;
            e.status    = STATUS_BAD_DIGIT;
            emit        = 1'b1;
         end
      end
      if (emit) begin
         expected_rsp.push_back(e);
         if (e.byte_valid) n_bytes++;
         if (e.line_done) n_line_ends++;
         if (e.status != STATUS_OK) n_errors++;
      end
   endtask

   // Compare one accepted response with the oldest expectation
   task automatic check_rsp(input rsp_type a);
      rsp_type e;
      if (expected_rsp.size() == 0) begin
         $error("unexpected response: data_byte %0h byte_valid %0b line_done %0b status %0d",
                a.data_byte, a.byte_valid, a.line_done, a.status);
         fail_count++;
      end else begin
         e = expected_rsp.pop_front();
         if (a.data_byte !== e.data_byte) begin
            $error("data_byte: expected %0h, got %0h", e.data_byte, a.data_byte);
            fail_count++;
         end
         if (a.byte_valid !== e.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", e.byte_valid, a.byte_valid);
            fail_count++;
         end
         if (a.line_done !== e.line_done) begin
            $error("line_done: expected %0b, got %0b", e.line_done, a.line_done);
            fail_count++;
         end
         if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            fail_count++;
         end
      end
   endtask

   // Responses are checked before the same edge's request is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_rsp(rsp_payload);
         if (req_valid && !req_stall) decode_char(req_payload);
      end
      pending = expected_rsp.size();
   end

endmodule

@@ dv/uudecode_line_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// uudecode_line_decoder_tb
// Drives directed and random uuencoded lines into the decoder with random
// gaps and response stalls, including one long hold-off; the checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module uudecode_line_decoder_tb;
   import uld_pkg::*;

   localparam int unsigned LINE_ITEMS  = 550;
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   int fail_count;
   int pending;
   int n_bytes;
   int n_line_ends;
   int n_errors;

   int unsigned cycle_count = 0;
   int unsigned line_items  = 0;
   int unsigned n_chars     = 0;
   logic        tx_quiet    = 1'b0;

   always #1 clock = ~clock;

   uudecode_line_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   uudecode_line_decoder_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .fail_count (fail_count),
      .pending    (pending),
      .n_bytes    (n_bytes),
      .n_line_ends(n_line_ends),
      .n_errors   (n_errors)
   );

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
         $display("FAILURE");
         $finish;
      end
   end

   // Offer one character, called and returning at a falling edge
   task automatic send_char(input logic [7:0] c, input logic s);
      if (!tx_quiet && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{ch: c, line_start: s};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_chars++;
      @(negedge clock);
   endtask

   // One line with random digits, now and then corrupted mid-line
   task automatic send_line();
      int unsigned count;
      int unsigned n_digits;
      int unsigned corrupt_at;
      int unsigned pick;
      logic [5:0]  d;
      logic [7:0]  c;
      pick = $urandom_range(99);
      if (pick < 8) count = MAX_LINE_BYTES;
      else if (pick < 20) count = $urandom_range(0, MAX_LINE_BYTES);
      else count = $urandom_range(0, 9);
      n_digits   = (count * 4 + 2) / 3;
      corrupt_at = ($urandom_range(7) == 0) ? $urandom_range(0, n_digits) : n_digits + 1;
      c = (count == 0 && $urandom_range(1) == 1) ? CH_BACKQUOTE : CH_SPACE + 8'(count);
      send_char(c, 1'b1);
      for (int i = 0; i < n_digits; i++) begin
         if (i == corrupt_at) begin
            // any character, sometimes a restart
            send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
         end else begin
            d = 6'($urandom);
            c = (d == 6'd0 && $urandom_range(1) == 1) ? CH_BACKQUOTE : CH_SPACE + 8'(d);
            send_char(c, 1'b0);
         end
      end
      line_items += 1 + n_digits;
   endtask

   // Response side: random stalls, one long hold-off, one quiet stretch
   initial begin
      int unsigned rx_cycle;
      rx_cycle = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (rx_cycle >= 300 && rx_cycle < 364) rsp_stall <= 1'b1;
         else if (rx_cycle >= 500 && rx_cycle < 700) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(99) < 23);
         rx_cycle++;
      end
   end

   // Stimulus and verdict
   initial begin
      int unsigned pick;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: idle char, empty lines, bad lengths
      send_char("A", 1'b0);
      send_char(CH_BACKQUOTE, 1'b1);
      send_char(CH_SPACE, 1'b1);
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      send_char(LEN_TOP + 8'd1, 1'b1);
      // one byte, then three bytes with extreme digits, then an ignored char
      send_char("!", 1'b1);
      send_char("Q", 1'b0);
      send_char(CH_BACKQUOTE, 1'b0);
      send_char("#", 1'b1);
      send_char(DIGIT_TOP, 1'b0);
      send_char(CH_SPACE, 1'b0);
      send_char(CH_BACKQUOTE, 1'b0);
      send_char("5", 1'b0);
      send_char("B", 1'b0);
      // bad digit on the first digit, restart inside a line
      send_char("\"", 1'b1);
      send_char("x", 1'b0);
      send_char("$", 1'b1);
      send_char("0", 1'b0);
      send_char("1", 1'b0);
      send_char(CH_BACKQUOTE, 1'b1);
      // longest length, bad digit above and below the digit range
      send_char(LEN_TOP, 1'b1);
      send_char("!", 1'b0);
      send_char("~", 1'b0);
      send_char("%", 1'b1);
      send_char(8'h1F, 1'b0);

      // random: mostly well-formed lines, some noise and bad lengths
      while (line_items < LINE_ITEMS) begin
         tx_quiet = (line_items >= 200 && line_items < 320);
         pick = $urandom_range(99);
         if (pick < 80) begin
            send_line();
         end else if (pick < 90) begin
            send_char(8'($urandom_range(255)), 1'b1);
            line_items++;
         end else begin
            repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)), 1'b0);
         end
      end
      req_valid <= 1'b0;

      // drain
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Sent %0d characters; checked %0d decoded bytes and %0d line ends, %0d with errors.",
               n_chars, n_bytes, n_line_ends, n_errors);
      $display("Lines: empty, longest, restarted, corrupted; response side held off 64 cycles.");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
